>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of the frame chunker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/dfc_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the chunker.
// No dependencies.
`timescale 1ns / 1ps

package dfc_pkg;

  localparam int unsigned MaxResults   = 5;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] SplitFlag    = 16'h0400;
  localparam logic [9:0]  LimitReset   = 10'd996;

  typedef enum logic [2:0] {
    PH_HIGH    = 3'b001,
    PH_LOW     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  // Results caused by one input beat, in output order from index 0.
  typedef struct packed {
    logic [2:0]                      cnt;
    logic [MaxResults-1:0][7:0]      bytes;
    logic [MaxResults-1:0]           ends;
    logic                            err;
  } dfc_entry_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    x = x ^ {12'h000, x[7:4]};
    x = x ^ {x[3:0], 12'h000};
    x = x ^ {3'b000, x[7:0], 5'b00000};
    return x;
  endfunction

endpackage

>>> rtl/download_frame_chunker_crc16.sv
// Top level of the length-prefixed frame chunker with CRC-16/CCITT-FALSE.
// Depends on dfc_pkg, dfc_front, dfc_fifo and dfc_back.
//
// Input channel (in_valid_i/in_ready_o): one image byte per beat, with
// sequence_end_i set on the last byte of the image. Output channel
// (out_valid_o/out_ready_i): one frame byte per beat, flagged with frame_end_o
// on the closing CRC byte, run_last_o on the last result of an input beat and
// sequence_error_o when the image stopped inside a frame.
// cfg_we_i writes cfg_wdata_i into the chunk limit; write it only while idle.
// Throughput: one input beat per cycle while the queue has room, one output beat per
// cycle while the receiver is ready. An input beat yields zero to five results; header
// and CRC bursts are absorbed by the FifoDepth-entry queue between front and back end.
// With the back end idle, the first result of a beat is written into the entry queue
// on the accepting edge and then loaded into the output register.
// in_ready_o drops only while the entry queue is full.
// When the receiver stalls, the current result holds and the front end keeps
// taking bytes until the queue fills. Reset empties the queue, returns parsing
// to the length high byte and sets the chunk limit to 996.
`timescale 1ns / 1ps

module download_frame_chunker_crc16 #(
  parameter int unsigned FifoDepth = dfc_pkg::FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] image_byte_i,
  input  logic       sequence_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output logic       run_last_o,
  output logic       sequence_error_o
);
  import dfc_pkg::*;

  logic [9:0] chunk_limit_q;
  logic       push, full, pop, empty;
  dfc_entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      chunk_limit_q <= cfg_wdata_i;
    end
  end

  dfc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .image_byte_i   (image_byte_i),
    .sequence_end_i (sequence_end_i),
    .chunk_limit_i  (chunk_limit_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  dfc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  dfc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .frame_end_o      (frame_end_o),
    .run_last_o       (run_last_o),
    .sequence_error_o (sequence_error_o)
  );

endmodule

>>> rtl/dfc_front.sv
// Front end: parses length headers and payload, runs the CRC and builds one
// result entry for each input beat that yields results. Depends on dfc_pkg.
`timescale 1ns / 1ps

module dfc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          image_byte_i,
  input  logic                sequence_end_i,
  input  logic [9:0]          chunk_limit_i,
  input  logic                full_i,
  output logic                push_o,
  output dfc_pkg::dfc_entry_t entry_o
);
  import dfc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] frame_rem_q, frame_rem_d;
  logic [9:0]  chunk_rem_q, chunk_rem_d;
  logic [15:0] crc_q, crc_d;

  logic        accept;
  logic [9:0]  lim;
  logic [15:0] fr_sel;
  logic [15:0] fr_dec;
  logic [9:0]  chunk_dec;
  logic [15:0] hdr;
  logic [9:0]  hdr_chunk;
  logic [15:0] hdr_crc;
  logic [15:0] pay_crc;
  dfc_entry_t  ent;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign lim       = (chunk_limit_i == 10'd0) ? 10'd1 : chunk_limit_i;
  assign fr_dec    = frame_rem_q - 16'd1;
  assign chunk_dec = chunk_rem_q - 10'd1;
  assign fr_sel    = (phase_q == PH_LOW) ? {held_q, image_byte_i} : fr_dec;

  // One header unit serves both a new frame and the next chunk of a split frame.
  always_comb begin
    if (fr_sel > {6'd0, lim}) begin
      hdr       = SplitFlag | {6'd0, lim};
      hdr_chunk = lim;
    end else begin
      hdr       = fr_sel;
      hdr_chunk = fr_sel[9:0];
    end
  end

  assign hdr_crc = crc_update(crc_update(CrcInit, hdr[15:8]), hdr[7:0]);
  assign pay_crc = crc_update(crc_q, image_byte_i);

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    frame_rem_d = frame_rem_q;
    chunk_rem_d = chunk_rem_q;
    crc_d       = crc_q;
    ent         = '0;

    unique case (phase_q)
      PH_LOW: begin
        frame_rem_d  = fr_sel;
        chunk_rem_d  = hdr_chunk;
        ent.bytes[0] = hdr[15:8];
        ent.bytes[1] = hdr[7:0];
        if (fr_sel == 16'd0) begin
          ent.bytes[2] = hdr_crc[15:8];
          ent.bytes[3] = hdr_crc[7:0];
          ent.ends[3]  = 1'b1;
          ent.cnt      = 3'd4;
          crc_d        = CrcInit;
          phase_d      = PH_HIGH;
        end else begin
          ent.cnt = 3'd2;
          crc_d   = hdr_crc;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ent.bytes[0] = image_byte_i;
        ent.cnt      = 3'd1;
        crc_d        = pay_crc;
        frame_rem_d  = fr_dec;
        chunk_rem_d  = chunk_dec;
        if (chunk_dec == 10'd0) begin
          ent.bytes[1] = pay_crc[15:8];
          ent.bytes[2] = pay_crc[7:0];
          ent.ends[2]  = 1'b1;
          if (fr_dec == 16'd0) begin
            ent.cnt = 3'd3;
            crc_d   = CrcInit;
            phase_d = PH_HIGH;
          end else begin
            // close this chunk and open the next
            ent.bytes[3] = hdr[15:8];
            ent.bytes[4] = hdr[7:0];
            ent.cnt      = 3'd5;
            chunk_rem_d  = hdr_chunk;
            crc_d        = hdr_crc;
          end
        end
      end
      default: begin
        held_d  = image_byte_i;
        phase_d = PH_LOW;
      end
    endcase

    if (sequence_end_i) begin
      if (phase_d != PH_HIGH) begin
        if (ent.cnt == 3'd0) begin
          ent.cnt      = 3'd1;
          ent.bytes[0] = 8'h00;
          ent.ends[0]  = 1'b0;
        end
        ent.err = 1'b1;
      end
      phase_d     = PH_HIGH;
      held_d      = 8'h00;
      frame_rem_d = 16'd0;
      chunk_rem_d = 10'd0;
      crc_d       = CrcInit;
    end
  end

  assign push_o  = accept && (ent.cnt != 3'd0);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HIGH;
      held_q      <= 8'h00;
      frame_rem_q <= 16'd0;
      chunk_rem_q <= 10'd0;
      crc_q       <= CrcInit;
    end else if (accept) begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      frame_rem_q <= frame_rem_d;
      chunk_rem_q <= chunk_rem_d;
      crc_q       <= crc_d;
    end
  end

endmodule

>>> rtl/dfc_fifo.sv
// Entry queue between front end and back end; pointers wrap at Depth - 1 for any depth.
// Depends on dfc_pkg.
`timescale 1ns / 1ps

module dfc_fifo #(
  parameter int unsigned Depth = dfc_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dfc_pkg::dfc_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output dfc_pkg::dfc_entry_t head_o
);
  import dfc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dfc_entry_t        mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/dfc_back.sv
// Back end: holds one entry and sends its results out one beat at a time.
// Depends on dfc_pkg.
`timescale 1ns / 1ps

module dfc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  dfc_pkg::dfc_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                frame_end_o,
  output logic                run_last_o,
  output logic                sequence_error_o
);
  import dfc_pkg::*;

  dfc_entry_t cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;
  logic       last_res;
  logic       take;

  assign last_res = (idx_q == (cur_q.cnt - 3'd1));
  assign take     = cur_valid_q && out_ready_i;
  assign pop_o    = !empty_i && (!cur_valid_q || (take && last_res));

  assign out_valid_o      = cur_valid_q;
  assign frame_byte_o     = cur_q.bytes[idx_q];
  assign frame_end_o      = cur_q.ends[idx_q];
  assign run_last_o       = last_res;
  assign sequence_error_o = last_res && cur_q.err;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 3'd0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= 3'd0;
    end else if (take) begin
      // advance within the entry, drop it after its last result
      if (last_res) begin
        cur_valid_q <= 1'b0;
        idx_q       <= 3'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

>>> rtl/dfc_checker.sv
// Port-level checks on the chunker output channel, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       frame_end_o,
  input logic       run_last_o,
  input logic       sequence_error_o
);

  `ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_byte_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(frame_byte_o))
  `ASSERT_ALWAYS(a_err_on_last, clk_i, rst_ni, !out_valid_o || !sequence_error_o || run_last_o)
  `ASSERT_ALWAYS(a_err_not_end, clk_i, rst_ni, !out_valid_o || !(sequence_error_o && frame_end_o))

endmodule

bind download_frame_chunker_crc16 dfc_checker u_dfc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_byte_o     (frame_byte_o),
  .frame_end_o      (frame_end_o),
  .run_last_o       (run_last_o),
  .sequence_error_o (sequence_error_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for download_frame_chunker_crc16.
// Needs dfc_pkg and the chunker RTL; output beats are checked against results typed
// into pinned rows, else an in-bench chunker predictor; directed table, then random frames.
`timescale 1ns / 1ps

module tb_top;
  import dfc_pkg::*;

  localparam int unsigned TotalBeats   = 410;
  localparam int unsigned PhaseBeats   = 48;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned ReportMax    = 10;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
    logic       rlast;
    logic       serr;
  } frame_beat_t;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_e;

  // A pinned row carries its results typed in: n beats, bytes b0 then b1.
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic [9:0] lim;
    logic       pinned;
    logic [2:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       err;
  } stim_row_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [9:0] cfg_wdata_i    = '0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] image_byte_i   = '0;
  logic       sequence_end_i = 1'b0;
  logic       out_ready_i    = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] frame_byte_o;
  logic       frame_end_o;
  logic       run_last_o;
  logic       sequence_error_o;

  always #1 clk_i = ~clk_i;

  download_frame_chunker_crc16 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .image_byte_i    (image_byte_i),
    .sequence_end_i  (sequence_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_byte_o    (frame_byte_o),
    .frame_end_o     (frame_end_o),
    .run_last_o      (run_last_o),
    .sequence_error_o(sequence_error_o)
  );

  // Predictor state of the chunker.
  logic [9:0]  lim_reg = LimitReset;
  phase_e      ph;
  logic [7:0]  len_hi;
  logic [15:0] frame_left;
  logic [9:0]  chunk_left;
  logic [15:0] crc;

  frame_beat_t step_beats[$];
  frame_beat_t frames_due[$];
  stim_row_t   stim_rows[$];

  int unsigned beats_sent    = 0;
  int unsigned limit_writes  = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_closed = 0;
  int unsigned errors_seen   = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;
  bit          in_calm       = 1'b0;
  bit          out_calm      = 1'b0;
  int unsigned ready_hold    = 0;

  function automatic stim_row_t row_free(input logic [7:0] data, input logic last);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_BEAT;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  function automatic stim_row_t row_pinned(input logic [7:0] data, input logic last,
                                           input logic [2:0] n, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic err);
    stim_row_t r;
    r        = row_free(data, last);
    r.pinned = 1'b1;
    r.n      = n;
    r.b0     = b0;
    r.b1     = b1;
    r.err    = err;
    return r;
  endfunction

  function automatic stim_row_t row_limit(input logic [9:0] lim);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_LIMIT;
    r.lim  = lim;
    return r;
  endfunction

  task automatic clear_parse();
    ph         = PH_HIGH;
    len_hi     = '0;
    frame_left = '0;
    chunk_left = '0;
    crc        = CrcInit;
  endtask

  // Fold a byte into the running CRC (poly 0x1021, MSB first) and emit it.
  task automatic emit_data(input logic [7:0] d);
    frame_beat_t ent;
    crc = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++)
      crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
    ent       = '0;
    ent.fbyte = d;
    step_beats.push_back(ent);
  endtask

  task automatic emit_crc();
    frame_beat_t ent;
    ent       = '0;
    ent.fbyte = crc[15:8];
    step_beats.push_back(ent);
    ent.fbyte = crc[7:0];
    ent.fend  = 1'b1;
    step_beats.push_back(ent);
    crc = CrcInit;
  endtask

  task automatic open_chunk();
    logic [9:0]  l;
    logic [15:0] hdr;
    l = (lim_reg == 10'd0) ? 10'd1 : lim_reg;
    if (frame_left > {6'd0, l}) begin
      hdr        = {6'd0, l} | SplitFlag;
      chunk_left = l;
    end else begin
      hdr        = frame_left;
      chunk_left = frame_left[9:0];
    end
    emit_data(hdr[15:8]);
    emit_data(hdr[7:0]);
  endtask

  // Work out the output beats that one image byte causes.
  task automatic chunker_step(input logic [7:0] b, input logic last);
    frame_beat_t tail;
    step_beats.delete();
    case (ph)
      PH_LOW: begin
        frame_left = {len_hi, b};
        crc        = CrcInit;
        open_chunk();
        if (frame_left == 16'd0) begin
          emit_crc();
          ph = PH_HIGH;
        end else begin
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        emit_data(b);
        chunk_left = chunk_left - 10'd1;
        frame_left = frame_left - 16'd1;
        if (chunk_left == 10'd0) begin
          emit_crc();
          if (frame_left == 16'd0) ph = PH_HIGH;
          else open_chunk();
        end
      end
      default: begin
        len_hi = b;
        ph     = PH_LOW;
      end
    endcase
    if (last) begin
      // Image stopped inside a frame: flag it, with a marker beat if nothing else
      if (ph != PH_HIGH) begin
        if (step_beats.size() == 0) step_beats.push_back('0);
        tail      = step_beats.pop_back();
        tail.serr = 1'b1;
        step_beats.push_back(tail);
      end
      clear_parse();
    end
    if (step_beats.size() != 0) begin
      tail       = step_beats.pop_back();
      tail.rlast = 1'b1;
      step_beats.push_back(tail);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 99) < 4) in_calm = !in_calm;
    r = $urandom_range(0, 99);
    if (in_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic send_beat(input stim_row_t row);
    int unsigned gap;
    frame_beat_t ent;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    image_byte_i   <= row.data;
    sequence_end_i <= row.last;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    chunker_step(row.data, row.last);
    if (row.pinned) begin
      for (int k = 0; k < row.n; k++) begin
        ent.fbyte = (k == 0) ? row.b0 : row.b1;
        ent.fend  = 1'b0;
        ent.rlast = (k == row.n - 1);
        ent.serr  = row.err && (k == row.n - 1);
        frames_due.push_back(ent);
      end
    end else begin
      foreach (step_beats[k]) frames_due.push_back(step_beats[k]);
    end
  endtask

  // Hold off until every expected beat is out, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [9:0] v);
    wait_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_reg = v;
    limit_writes++;
  endtask

  // One image frame; some run long and get cut, some end the image early.
  task automatic send_frame();
    logic [15:0] len;
    int unsigned r, total, cut, n_send;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      len   = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
      total = 32'(len) + 2;
      cut   = $urandom_range(0, 7);
    end else begin
      if (r < 18)      len = 16'd0;
      else if (r < 85) len = 16'($urandom_range(1, 12));
      else             len = 16'($urandom_range(13, 40));
      total = 32'(len) + 2;
      r     = $urandom_range(0, 99);
      if (r < 15)      cut = $urandom_range(0, total - 2);
      else if (r < 35) cut = total - 1;
      else             cut = total;
    end
    n_send = (cut < total) ? cut + 1 : total;
    for (int i = 0; i < n_send; i++) begin
      if (i == 0)      send_beat(row_free(len[15:8], i == cut));
      else if (i == 1) send_beat(row_free(len[7:0], i == cut));
      else             send_beat(row_free(8'($urandom_range(0, 255)), i == cut));
    end
  endtask

  function automatic logic [9:0] limit_for_phase(input int unsigned p);
    case (p)
      0:       return 10'd1023;
      1:       return 10'd1;
      2:       return 10'd0;
      3:       return 10'd5;
      4:       return LimitReset;
      5:       return 10'd2;
      6:       return 10'd1023;
      default: return 10'($urandom_range(1, 24));
    endcase
  endfunction

  // Receiver: ready pattern with short and long stalls and calm stretches.
  always @(posedge clk_i) begin : ready_gen
    int unsigned r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      if ($urandom_range(0, 99) < 5) out_calm = !out_calm;
      r = $urandom_range(0, 99);
      if (out_calm) begin
        out_ready_i <= 1'b1;
        ready_hold  <= $urandom_range(20, 60);
      end else if (r < 55) begin
        out_ready_i <= 1'b1;
        ready_hold  <= $urandom_range(0, 5);
      end else if (r < 92) begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold  <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_beat_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.fbyte = frame_byte_o;
      got.fend  = frame_end_o;
      got.rlast = run_last_o;
      got.serr  = sequence_error_o;
      results_seen++;
      if (got.fend) frames_closed++;
      if (got.serr) errors_seen++;
      if (frames_due.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax)
          $display("unexpected beat: byte %h end %b last %b err %b",
                   got.fbyte, got.fend, got.rlast, got.serr);
      end else begin
        want = frames_due.pop_front();
        if (got.fbyte !== want.fbyte || got.fend !== want.fend ||
            got.rlast !== want.rlast || got.serr !== want.serr) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("beat %0d: expected byte %h end %b last %b err %b, got %h %b %b %b",
                     results_seen, want.fbyte, want.fend, want.rlast, want.serr,
                     got.fbyte, got.fend, got.rlast, got.serr);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (idle_cycles == StallLimit) begin
      $display("no beat accepted for %0d cycles", StallLimit);
      $display("download_frame_chunker_crc16 regression: fail");
      $finish;
    end else if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no, phase_end;
    clear_parse();
    // Reset limit 996: zero-length frame, short frame, byte extremes, cut frames
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_free(8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'h03, 1'b0, 3'd2, 8'h00, 8'h03, 1'b0));
    stim_rows.push_back(row_pinned(8'hFF, 1'b0, 3'd1, 8'hFF, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd1, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_free(8'h80, 1'b0));
    stim_rows.push_back(row_pinned(8'hFF, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'hFF, 1'b0, 3'd2, 8'h07, 8'hE4, 1'b0));
    stim_rows.push_back(row_pinned(8'h5A, 1'b0, 3'd1, 8'h5A, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'hA5, 1'b1, 3'd1, 8'hA5, 8'h00, 1'b1));
    stim_rows.push_back(row_pinned(8'h12, 1'b1, 3'd1, 8'h00, 8'h00, 1'b1));
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_free(8'h00, 1'b1));
    // Limit 2: chunk boundary with CRC plus next header on one byte
    stim_rows.push_back(row_limit(10'd2));
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'h05, 1'b0, 3'd2, 8'h04, 8'h02, 1'b0));
    stim_rows.push_back(row_pinned(8'h11, 1'b0, 3'd1, 8'h11, 8'h00, 1'b0));
    stim_rows.push_back(row_free(8'h22, 1'b0));
    stim_rows.push_back(row_pinned(8'h33, 1'b0, 3'd1, 8'h33, 8'h00, 1'b0));
    // Change the limit mid-frame; the open chunk keeps its length
    stim_rows.push_back(row_limit(10'd3));
    stim_rows.push_back(row_free(8'h44, 1'b0));
    stim_rows.push_back(row_free(8'h55, 1'b1));
    // Limit 0 acts as 1
    stim_rows.push_back(row_limit(10'd0));
    stim_rows.push_back(row_pinned(8'h00, 1'b0, 3'd0, 8'h00, 8'h00, 1'b0));
    stim_rows.push_back(row_pinned(8'h02, 1'b0, 3'd2, 8'h04, 8'h01, 1'b0));
    stim_rows.push_back(row_free(8'hFF, 1'b0));
    stim_rows.push_back(row_free(8'h00, 1'b0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_LIMIT) write_limit(stim_rows[i].lim);
      else send_beat(stim_rows[i]);
    end

    phase_no = 0;
    while (beats_sent < TotalBeats) begin
      write_limit(limit_for_phase(phase_no));
      phase_no++;
      phase_end = beats_sent + PhaseBeats;
      while (beats_sent < phase_end && beats_sent < TotalBeats) send_frame();
    end

    wait_drained();
    $display("sent %0d image bytes over %0d chunk limit settings (0, 1 and 1023 included)",
             beats_sent, limit_writes);
    $display("checked %0d frame beats: %0d frames closed, %0d sequence errors, %0d mismatches",
             results_seen, frames_closed, errors_seen, fail_count);
    if (fail_count == 0) begin
      $display("download_frame_chunker_crc16 regression: pass");
    end else begin
      $display("download_frame_chunker_crc16 regression: fail");
    end
    $finish;
  end

endmodule
